FILE: rtl/core/gcpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcpd_pkg
// shared types and constants of the glyph code pixel decoder
// ----------------------------------------------------------------------------
package gcpd_pkg;

    // opcode and operand bytes of the drawing routine
    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] OP_ADD      = 8'h03;
    localparam logic [7:0] ARG_ADD_ROW = 8'hF9;
    localparam logic [7:0] OP_MOV      = 8'h88;
    localparam logic [7:0] ARG_MOV_C0  = 8'h07;
    localparam logic [7:0] ARG_MOV_NN  = 8'h47;

    localparam int CFG_W     = 9;
    localparam int ROW_W     = 9;
    localparam int COUNT_W   = 13;

    localparam logic [ROW_W-1:0]   ROW_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] MAX_INSTRUCTIONS = 13'd4096;

    // configuration register indexes
    localparam logic CFG_GLYPH_WIDTH  = 1'b0;
    localparam logic CFG_GLYPH_HEIGHT = 1'b1;

    // request queue between decode and output
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_RETURN    = 2'd0,
        ST_BAD       = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_LIMIT     = 2'd3
    } t_status;

    typedef struct packed {
        logic       pixel_write;
        logic [7:0] pixel_row;
        logic [7:0] pixel_col;
        logic       glyph_done;
        t_status    end_status;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

`default_nettype wire

FILE: rtl/core/gcpd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcpd_front
// accepts code bytes, tracks decode phase, row and count, builds results
// ----------------------------------------------------------------------------
module gcpd_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [gcpd_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [7:0]                  i_code_byte,
    input  wire logic                        i_start_glyph,
    input  wire logic                        i_end_of_code,
    input  wire gcpd_pkg::t_queue_stat       i_qstat,
    output logic                             o_push,
    output gcpd_pkg::t_result                o_result
);
    import gcpd_pkg::*;

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_ADD,
        PH_MOV,
        PH_MOVNN
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_stopped, n_stopped;
    logic [CFG_W-1:0]   r_width, r_height;

    logic               accept;
    logic               pix, done, completed;
    logic [7:0]         pcol;
    t_status            status;
    t_phase             ph;
    logic [ROW_W-1:0]   row;
    logic [COUNT_W-1:0] cnt, cnt_inc;
    logic               stp;

    function automatic logic in_box(input logic [ROW_W-1:0] r, input logic [7:0] c,
                                    input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        return !r[ROW_W-1] && (r < h) && ({1'b0, c} < w);
    endfunction

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        ph        = r_phase;
        row       = r_row;
        cnt       = r_count;
        stp       = r_stopped;
        if (i_start_glyph) begin
            ph  = PH_OPCODE;
            row = '0;
            cnt = '0;
            stp = 1'b0;
        end
        pix       = 1'b0;
        done      = 1'b0;
        completed = 1'b0;
        pcol      = 8'd0;
        status    = ST_RETURN;
        n_phase   = ph;
        n_row     = row;
        n_count   = cnt;
        n_stopped = stp;
        cnt_inc   = (cnt != COUNT_MAX) ? cnt + COUNT_W'(1) : cnt;
        if (!stp) begin
            case (ph)
                PH_OPCODE: begin
                    if (i_code_byte == OP_RET) begin
                        done = 1'b1;
                    end else if (i_code_byte == OP_ADD || i_code_byte == OP_MOV) begin
                        if (i_end_of_code) begin
                            done   = 1'b1;
                            status = ST_BAD;
                        end else begin
                            n_phase = (i_code_byte == OP_ADD) ? PH_ADD : PH_MOV;
                        end
                    end else begin
                        done   = 1'b1;
                        status = ST_BAD;
                    end
                end
                PH_ADD: begin
                    if (i_code_byte == ARG_ADD_ROW) begin
                        if (row != ROW_MAX) n_row = row + ROW_W'(1);
                        completed = 1'b1;
                    end else begin
                        done   = 1'b1;
                        status = ST_BAD;
                    end
                end
                PH_MOV: begin
                    if (i_code_byte == ARG_MOV_C0) begin
                        pix       = in_box(row, 8'd0, r_width, r_height);
                        completed = 1'b1;
                    end else if (i_code_byte == ARG_MOV_NN) begin
                        if (i_end_of_code) begin
                            done   = 1'b1;
                            status = ST_BAD;
                        end else begin
                            n_phase = PH_MOVNN;
                        end
                    end else begin
                        done   = 1'b1;
                        status = ST_BAD;
                    end
                end
                PH_MOVNN: begin
                    pix       = in_box(row, i_code_byte, r_width, r_height);
                    pcol      = pix ? i_code_byte : 8'd0;
                    completed = 1'b1;
                end
                default: begin
                    done   = 1'b1;
                    status = ST_BAD;
                end
            endcase
            if (completed) begin
                n_phase = PH_OPCODE;
                n_count = cnt_inc;
                if (cnt_inc >= MAX_INSTRUCTIONS) begin
                    done   = 1'b1;
                    status = ST_LIMIT;
                end else if (i_end_of_code) begin
                    done   = 1'b1;
                    status = ST_EXHAUSTED;
                end
            end
            if (done) begin
                n_stopped = 1'b1;
                n_phase   = PH_OPCODE;
            end
        end
    end

    always_comb begin
        o_result.pixel_write = pix;
        o_result.pixel_row   = pix ? row[7:0] : 8'd0;
        o_result.pixel_col   = pcol;
        o_result.glyph_done  = done;
        o_result.end_status  = done ? status : ST_RETURN;
    end

    assign o_push = accept && (pix || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OPCODE;
            r_row     <= '0;
            r_count   <= '0;
            r_stopped <= 1'b1;
            r_width   <= '0;
            r_height  <= '0;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_row     <= n_row;
                r_count   <= n_count;
                r_stopped <= n_stopped;
            end
            if (i_cfg_we && i_cfg_idx == CFG_GLYPH_WIDTH) r_width <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_GLYPH_HEIGHT) r_height <= i_cfg_data;
        end
    end

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.glyph_done |=> r_stopped)
        else $error("front not stopped after glyph end");

    a_pix_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_result.pixel_write |->
            ({1'b0, o_result.pixel_row} < r_height) && ({1'b0, o_result.pixel_col} < r_width))
        else $error("pixel write outside glyph box");

    a_stopped_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> r_phase == PH_OPCODE)
        else $error("stopped decoder left mid-pattern");

endmodule

`default_nettype wire

FILE: rtl/core/gcpd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcpd_queue
// short request queue between the decode front and the output stage
// ----------------------------------------------------------------------------
module gcpd_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire gcpd_pkg::t_result    i_data,
    input  wire logic                 i_pop,
    output gcpd_pkg::t_result         o_data,
    output gcpd_pkg::t_queue_stat     o_stat
);
    import gcpd_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr, r_rptr;
    logic [QUEUE_CW-1:0]   r_cnt;
    logic                  do_push, do_pop;

    assign o_stat.full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) r_wptr <= r_wptr + QUEUE_AW'(1);
            if (do_pop) r_rptr <= r_rptr + QUEUE_AW'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QUEUE_CW'(1);
                2'b01:   r_cnt <= r_cnt - QUEUE_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

FILE: rtl/core/gcpd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcpd_back
// output register stage, drains the queue toward the receiver
// ----------------------------------------------------------------------------
module gcpd_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire gcpd_pkg::t_queue_stat i_qstat,
    input  wire gcpd_pkg::t_result    i_data,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output gcpd_pkg::t_result         o_result
);
    import gcpd_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    load;

    assign load     = !i_qstat.empty && (!r_valid || i_ready);
    assign o_pop    = load;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_result <= i_data;
    end

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_result))
        else $error("output request dropped or changed while stalled");

    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_result.pixel_write || r_result.glyph_done)
        else $error("empty request presented");

    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped request not presented");

endmodule

`default_nettype wire

FILE: rtl/core/glyph_code_pixel_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_code_pixel_decoder_top
// decodes glyph drawing routine bytes into pixel writes and end reports
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_ready with one code byte, start and end flags
//   output channel: o_valid / i_ready with one pixel write and/or glyph end
//   configuration: i_cfg_we with i_cfg_idx 0 width, 1 height, written idle
//   throughput: one code byte per cycle while o_ready is high; bytes that
//   give nothing use no output slot
//   path: a result is written into the queue at the edge that takes its
//   byte, then moves on into the output register that drives o_valid
//   a four-entry queue sits between decode and output register; when the
//   receiver stalls the queue fills and o_ready falls once it is full
//   reset: decoder idle and stopped until a byte with start, row and count
//   zero, queue empty, no output request, width and height zero
// ----------------------------------------------------------------------------
module glyph_code_pixel_decoder_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [gcpd_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [7:0]                  i_code_byte,
    input  wire logic                        i_start_glyph,
    input  wire logic                        i_end_of_code,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_pixel_write,
    output logic [7:0]                       o_pixel_row,
    output logic [7:0]                       o_pixel_col,
    output logic                             o_glyph_done,
    output logic [1:0]                       o_end_status
);
    import gcpd_pkg::*;

    t_queue_stat qstat;
    t_result     push_data, head_data, out_data;
    logic        push, pop;

    gcpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_code_byte   (i_code_byte),
        .i_start_glyph (i_start_glyph),
        .i_end_of_code (i_end_of_code),
        .i_qstat       (qstat),
        .o_push        (push),
        .o_result      (push_data)
    );

    gcpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_stat  (qstat)
    );

    gcpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .i_data   (head_data),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_data)
    );

    assign o_pixel_write = out_data.pixel_write;
    assign o_pixel_row   = out_data.pixel_row;
    assign o_pixel_col   = out_data.pixel_col;
    assign o_glyph_done  = out_data.glyph_done;
    assign o_end_status  = out_data.end_status;

endmodule

`default_nettype wire
